// ----- sv/fca_pkg.sv -----
package fca_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int MAX_EXTENTS = 16;
    localparam int LEN_W       = OFFSET_BITS + 1;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

    localparam logic [LEN_W-1:0] HEAP_MAX = LEN_W'(1) << OFFSET_BITS;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_FIT     = 2'd1,
        ST_BAD_OFFSET = 2'd2,
        ST_TABLE_FULL = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_LOAD,
        CMD_FROM_RIGHT,
        CMD_FROM_LEFT
    } t_cell_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] start;
        logic [LEN_W-1:0]       len;
    } t_extent;

    typedef struct packed {
        logic fit;
        logic below;
    } t_cell_flags;

endpackage

// ----- sv/first_fit_coalescing_allocator.sv -----
// First-fit heap allocator with coalescing free list. The free extents live in a row of
// MAX_EXTENTS cells, kept in address order; cells at or above the extent count are unused.
// An accepted request has a compare phase, then an apply phase. In the first every cell
// compares its extent with the request at once and the first fitting entry and the insertion
// point are picked; in the second the row is updated, at most one cell loaded and, to remove
// or open an entry, the cells past that point shifting by one toward their neighbor. The
// apply phase waits for a free result slot, and a new request can be taken in it. A write
// of heap_size resets the table to one extent covering the heap (values above 65536 are
// clipped) and clears the used count; write it only while no request is in flight.
module first_fit_coalescing_allocator
    import fca_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [LEN_W-1:0]       i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_op,
    input  logic [LEN_W-1:0]       i_req_size,
    input  logic [OFFSET_BITS-1:0] i_free_offset,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OFFSET_BITS-1:0] o_alloc_offset,
    output logic [1:0]             o_status,
    output logic [LEN_W-1:0]       o_used_bytes,
    output logic [CNT_W-1:0]       o_free_extents
);

    t_state r_state, n_state;

    logic [LEN_W-1:0] r_heap;
    logic [CNT_W-1:0] r_count;
    logic [LEN_W-1:0] r_used;

    // request
    t_op                    r_op;
    logic [LEN_W-1:0]       r_size;
    logic [OFFSET_BITS-1:0] r_off;

    // compare-phase results
    logic             r_ff_found;
    logic [IDX_W-1:0] r_ff_idx;
    t_extent          r_ff_ext;
    logic [CNT_W-1:0] r_pos;
    t_extent          r_prev_ext;
    t_extent          r_next_ext;
    logic             r_off_bad;
    logic [LEN_W-1:0] r_size_c;

    // result slot
    logic                   r_out_valid;
    logic [OFFSET_BITS-1:0] r_alloc_offset;
    t_status                r_status;
    logic [LEN_W-1:0]       r_out_used;
    logic [CNT_W-1:0]       r_out_count;

    logic in_xfer, slot_free, do_cmp, do_apply, init;
    logic [LEN_W-1:0] cfg_sat;
    t_extent          init_ext;

    t_extent     ext   [MAX_EXTENTS];
    t_cell_flags flags [MAX_EXTENTS];
    t_cell_cmd   cmd   [MAX_EXTENTS];
    t_extent     left  [MAX_EXTENTS];
    t_extent     right [MAX_EXTENTS];

    // compare phase
    logic             c_ff_found;
    logic [IDX_W-1:0] c_ff_idx;
    logic [CNT_W-1:0] c_pos;
    logic [IDX_W-1:0] c_pos_m1;
    logic [LEN_W-1:0] c_rem;

    // apply phase
    logic [LEN_W-1:0]   prev_end, off_ext, end_new;
    logic               has_prev, has_next, m_prev, touch_next, m_both, m_next, f_ins, f_full;
    logic [LEN_W-1:0]   a_len;
    logic [LEN_W:0]     used_sum;
    logic               load_en, shl_en, shr_en;
    logic [IDX_W-1:0]   load_idx;
    logic [CNT_W-1:0]   shl_idx;
    t_extent            load_ext, cell_load;
    t_status            ap_status;
    logic [OFFSET_BITS-1:0] ap_offset;
    logic [CNT_W-1:0]   ap_count;
    logic [LEN_W-1:0]   ap_used;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign cfg_sat   = (i_cfg_wdata > HEAP_MAX) ? HEAP_MAX : i_cfg_wdata;
    assign init      = !i_rst_n || i_cfg_we;
    assign init_ext  = '{start: '0, len: (!i_rst_n ? HEAP_MAX : cfg_sat)};
    assign cell_load = init ? init_ext : load_ext;

    // state machine: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_xfer) n_state = S_CMP;
            S_CMP:   n_state = S_APPLY;
            S_APPLY: begin
                if (slot_free) begin
                    n_state = in_xfer ? S_CMP : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state machine: outputs
    always_comb begin
        slot_free  = !r_out_valid || i_out_ready;
        do_cmp     = 1'b0;
        do_apply   = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_CMP:   do_cmp = 1'b1;
            S_APPLY: begin
                do_apply   = slot_free;
                o_in_ready = slot_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    // cell row
    for (genvar g = 0; g < MAX_EXTENTS; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign left[g] = '0;
        end else begin : g_mid_l
            assign left[g] = ext[g-1];
        end
        if (g == MAX_EXTENTS - 1) begin : g_last
            assign right[g] = '0;
        end else begin : g_mid_r
            assign right[g] = ext[g+1];
        end

        always_comb begin
            if (init) begin
                cmd[g] = (g == 0) ? CMD_LOAD : CMD_HOLD;
            end else if (!do_apply) begin
                cmd[g] = CMD_HOLD;
            end else if (load_en && IDX_W'(g) == load_idx) begin
                cmd[g] = CMD_LOAD;
            end else if (shl_en && CNT_W'(g) >= shl_idx) begin
                cmd[g] = CMD_FROM_RIGHT;
            end else if (shr_en && CNT_W'(g) > r_pos) begin
                cmd[g] = CMD_FROM_LEFT;
            end else begin
                cmd[g] = CMD_HOLD;
            end
        end

        fca_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd[g]),
            .i_load  (cell_load),
            .i_left  (left[g]),
            .i_right (right[g]),
            .i_size  (r_size),
            .i_off   (r_off),
            .o_ext   (ext[g]),
            .o_flags (flags[g])
        );
    end

    // first fit and insertion point: lowest held cell that matches
    always_comb begin
        c_ff_found = 1'b0;
        c_ff_idx   = '0;
        c_pos      = r_count;
        for (int k = MAX_EXTENTS - 1; k >= 0; k--) begin
            if (CNT_W'(k) < r_count && flags[k].fit) begin
                c_ff_found = 1'b1;
                c_ff_idx   = IDX_W'(k);
            end
            if (CNT_W'(k) < r_count && !flags[k].below) begin
                c_pos = CNT_W'(k);
            end
        end
        c_pos_m1 = IDX_W'(c_pos - CNT_W'(1));
        c_rem    = r_heap - LEN_W'(r_off);
    end

    // update decision
    always_comb begin
        prev_end   = LEN_W'(r_prev_ext.start) + r_prev_ext.len;
        off_ext    = LEN_W'(r_off);
        end_new    = off_ext + r_size_c;
        has_prev   = (r_pos != '0);
        has_next   = (r_pos < r_count);
        m_prev     = has_prev && (prev_end == off_ext);
        touch_next = has_next && (end_new == LEN_W'(r_next_ext.start));
        m_both     = m_prev && touch_next;
        m_next     = !m_prev && touch_next;
        f_ins      = !m_prev && !touch_next;
        f_full     = f_ins && (r_count >= CNT_W'(MAX_EXTENTS));
        a_len      = r_ff_ext.len - r_size;
        used_sum   = (LEN_W+1)'(r_used) + (LEN_W+1)'(r_size);

        load_en   = 1'b0;
        load_idx  = r_ff_idx;
        load_ext  = r_ff_ext;
        shl_en    = 1'b0;
        shl_idx   = r_pos;
        shr_en    = 1'b0;
        ap_status = ST_OK;
        ap_offset = '0;
        ap_count  = r_count;
        ap_used   = r_used;

        if (r_op == OP_ALLOC) begin
            if (r_ff_found) begin
                ap_offset      = r_ff_ext.start;
                load_ext.start = OFFSET_BITS'(LEN_W'(r_ff_ext.start) + r_size);
                load_ext.len   = a_len;
                if (a_len == '0) begin
                    // extent used up: close the gap
                    shl_en   = 1'b1;
                    shl_idx  = CNT_W'(r_ff_idx);
                    ap_count = r_count - CNT_W'(1);
                end else begin
                    load_en = 1'b1;
                end
                ap_used = (used_sum > (LEN_W+1)'(HEAP_MAX)) ? HEAP_MAX : LEN_W'(used_sum);
            end else begin
                ap_status = ST_NO_FIT;
            end
        end else begin
            if (r_off_bad) begin
                ap_status = ST_BAD_OFFSET;
            end else if (r_size_c == '0) begin
                ap_status = ST_OK;
            end else if (f_full) begin
                ap_status = ST_TABLE_FULL;
            end else begin
                ap_used = (r_used > r_size_c) ? (r_used - r_size_c) : '0;
                load_en = 1'b1;
                if (m_prev) begin
                    load_idx       = IDX_W'(r_pos - CNT_W'(1));
                    load_ext.start = r_prev_ext.start;
                    load_ext.len   = r_prev_ext.len + r_size_c
                                   + (m_both ? r_next_ext.len : '0);
                    if (m_both) begin
                        shl_en   = 1'b1;
                        shl_idx  = r_pos;
                        ap_count = r_count - CNT_W'(1);
                    end
                end else if (m_next) begin
                    load_idx       = r_pos[IDX_W-1:0];
                    load_ext.start = r_off;
                    load_ext.len   = r_next_ext.len + r_size_c;
                end else begin
                    // open a slot at the insertion point
                    load_idx       = r_pos[IDX_W-1:0];
                    load_ext.start = r_off;
                    load_ext.len   = r_size_c;
                    shr_en         = 1'b1;
                    ap_count       = r_count + CNT_W'(1);
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_heap      <= HEAP_MAX;
            r_count     <= CNT_W'(1);
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_heap  <= cfg_sat;
                r_count <= (cfg_sat != '0) ? CNT_W'(1) : '0;
                r_used  <= '0;
            end else if (do_apply) begin
                r_count <= ap_count;
                r_used  <= ap_used;
            end
            if (do_apply) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op   <= t_op'(i_op);
            r_size <= i_req_size;
            r_off  <= i_free_offset;
        end
        if (do_cmp) begin
            r_ff_found <= c_ff_found;
            r_ff_idx   <= c_ff_idx;
            r_ff_ext   <= ext[c_ff_idx];
            r_pos      <= c_pos;
            r_prev_ext <= ext[c_pos_m1];
            r_next_ext <= ext[c_pos[IDX_W-1:0]];
            r_off_bad  <= (LEN_W'(r_off) >= r_heap);
            r_size_c   <= (r_size > c_rem) ? c_rem : r_size;
        end
        if (do_apply) begin
            r_alloc_offset <= ap_offset;
            r_status       <= ap_status;
            r_out_used     <= ap_used;
            r_out_count    <= ap_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_alloc_offset = r_alloc_offset;
    assign o_status       = r_status;
    assign o_used_bytes   = r_out_used;
    assign o_free_extents = r_out_count;

endmodule

// ----- sv/fca_cell.sv -----
module fca_cell
    import fca_pkg::*;
(
    input  logic                   i_clk,
    input  t_cell_cmd              i_cmd,
    input  t_extent                i_load,
    input  t_extent                i_left,
    input  t_extent                i_right,
    input  logic [LEN_W-1:0]       i_size,
    input  logic [OFFSET_BITS-1:0] i_off,
    output t_extent                o_ext,
    output t_cell_flags            o_flags
);

    t_extent r_ext;
    t_extent n_ext;

    always_comb begin
        case (i_cmd)
            CMD_HOLD:       n_ext = r_ext;
            CMD_LOAD:       n_ext = i_load;
            CMD_FROM_RIGHT: n_ext = i_right;
            CMD_FROM_LEFT:  n_ext = i_left;
            default:        n_ext = r_ext;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ext <= n_ext;
    end

    assign o_ext         = r_ext;
    assign o_flags.fit   = (r_ext.len >= i_size);
    assign o_flags.below = (r_ext.start < i_off);

endmodule

// ----- bench/tb_first_fit_coalescing_allocator.sv -----
module tb_first_fit_coalescing_allocator;
    import fca_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT     = 600000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 10;
    localparam int PRINT_CAP     = 40;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] offset;
        t_status                status;
        logic [LEN_W-1:0]       used;
        logic [CNT_W-1:0]       extents;
    } t_alloc_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [LEN_W-1:0]       i_cfg_wdata = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic                   i_op = 1'b0;
    logic [LEN_W-1:0]       i_req_size = '0;
    logic [OFFSET_BITS-1:0] i_free_offset = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [OFFSET_BITS-1:0] o_alloc_offset;
    logic [1:0]             o_status;
    logic [LEN_W-1:0]       o_used_bytes;
    logic [CNT_W-1:0]       o_free_extents;

    // shadow of the free list
    logic [LEN_W-1:0]       heap_bytes;
    logic [OFFSET_BITS-1:0] ext_start [MAX_EXTENTS];
    logic [LEN_W-1:0]       ext_len [MAX_EXTENTS];
    int                     ext_count;
    logic [LEN_W-1:0]       used_count;

    t_alloc_result awaited_replies[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int requests_sent = 0;
    int replies_checked = 0;
    int heap_writes = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    first_fit_coalescing_allocator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_req_size     (i_req_size),
        .i_free_offset  (i_free_offset),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_alloc_offset (o_alloc_offset),
        .o_status       (o_status),
        .o_used_bytes   (o_used_bytes),
        .o_free_extents (o_free_extents)
    );

    always #1 i_clk = ~i_clk;

    function automatic void heap_reinit(logic [LEN_W-1:0] value);
        heap_bytes = (value > HEAP_MAX) ? HEAP_MAX : value;
        for (int k = 0; k < MAX_EXTENTS; k++) begin
            ext_start[k] = '0;
            ext_len[k]   = '0;
        end
        ext_len[0] = heap_bytes;
        ext_count  = (heap_bytes != 0) ? 1 : 0;
        used_count = '0;
    endfunction

    function automatic void drop_extent(int pos);
        for (int k = pos; k + 1 < ext_count; k++) begin
            ext_start[k] = ext_start[k + 1];
            ext_len[k]   = ext_len[k + 1];
        end
        ext_count--;
        ext_start[ext_count] = '0;
        ext_len[ext_count]   = '0;
    endfunction

    function automatic t_status carve_block(int size, output int where);
        int total;
        where = 0;
        for (int k = 0; k < ext_count; k++) begin
            if (int'(ext_len[k]) >= size) begin
                where        = int'(ext_start[k]);
                ext_start[k] = OFFSET_BITS'(int'(ext_start[k]) + size);
                ext_len[k]   = LEN_W'(int'(ext_len[k]) - size);
                if (ext_len[k] == 0) begin
                    drop_extent(k);
                end
                total      = int'(used_count) + size;
                used_count = (total > int'(HEAP_MAX)) ? HEAP_MAX : LEN_W'(total);
                return ST_OK;
            end
        end
        return ST_NO_FIT;
    endfunction

    function automatic t_status return_block(int off, int size);
        int pos;
        if (off >= int'(heap_bytes)) begin
            return ST_BAD_OFFSET;
        end
        if (size > int'(heap_bytes) - off) begin
            size = int'(heap_bytes) - off;
        end
        if (size == 0) begin
            return ST_OK;
        end
        pos = 0;
        while (pos < ext_count && int'(ext_start[pos]) < off) begin
            pos++;
        end
        if (pos > 0 && int'(ext_start[pos-1]) + int'(ext_len[pos-1]) == off) begin
            ext_len[pos-1] = LEN_W'(int'(ext_len[pos-1]) + size);
            if (pos < ext_count &&
                int'(ext_start[pos-1]) + int'(ext_len[pos-1]) == int'(ext_start[pos])) begin
                ext_len[pos-1] = LEN_W'(int'(ext_len[pos-1]) + int'(ext_len[pos]));
                drop_extent(pos);
            end
        end else if (pos < ext_count && off + size == int'(ext_start[pos])) begin
            ext_start[pos] = OFFSET_BITS'(off);
            ext_len[pos]   = LEN_W'(int'(ext_len[pos]) + size);
        end else begin
            if (ext_count >= MAX_EXTENTS) begin
                return ST_TABLE_FULL;
            end
            for (int k = ext_count; k > pos; k--) begin
                ext_start[k] = ext_start[k - 1];
                ext_len[k]   = ext_len[k - 1];
            end
            ext_start[pos] = OFFSET_BITS'(off);
            ext_len[pos]   = LEN_W'(size);
            ext_count++;
        end
        used_count = (int'(used_count) > size) ? LEN_W'(int'(used_count) - size) : '0;
        return ST_OK;
    endfunction

    function automatic t_alloc_result heap_request_outcome(t_op op, logic [LEN_W-1:0] req,
                                                           logic [OFFSET_BITS-1:0] off);
        t_alloc_result r;
        int where;
        where = 0;
        if (op == OP_ALLOC) begin
            r.status = carve_block(int'(req), where);
            if (r.status != ST_OK) begin
                where = 0;
            end
        end else begin
            r.status = return_block(int'(off), int'(req));
        end
        r.offset  = OFFSET_BITS'(where);
        r.used    = used_count;
        r.extents = CNT_W'(ext_count);
        return r;
    endfunction

    task automatic report_mismatch(string field, int want, int got);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("MISMATCH reply %0d: %s expected %0d, got %0d",
                     replies_checked, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : reply_checker
        t_alloc_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_replies.size() == 0) begin
                report_mismatch("unexpected reply, status", 0, int'(o_status));
            end else begin
                want = awaited_replies.pop_front();
                replies_checked++;
                if (o_alloc_offset !== want.offset)
                    report_mismatch("alloc_offset", int'(want.offset), int'(o_alloc_offset));
                if (o_status !== want.status)
                    report_mismatch("status", int'(want.status), int'(o_status));
                if (o_used_bytes !== want.used)
                    report_mismatch("used_bytes", int'(want.used), int'(o_used_bytes));
                if (o_free_extents !== want.extents)
                    report_mismatch("free_extents", int'(want.extents), int'(o_free_extents));
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_request(input t_op op, input logic [LEN_W-1:0] req,
                                input logic [OFFSET_BITS-1:0] off, output t_alloc_result res);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_req_size    <= req;
        i_free_offset <= off;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = heap_request_outcome(op, req, off);
        awaited_replies = {awaited_replies, res};
        requests_sent++;
        status_seen[res.status]++;
    endtask

    task automatic wait_drained(int settle);
        i_in_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_heap_size(logic [LEN_W-1:0] value);
        wait_drained(SETTLE_CYCLES);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        heap_reinit(value);
        heap_writes++;
    endtask

    task automatic test_boundary_requests();
        t_alloc_result res;
        send_request(OP_ALLOC, 0, '1, res);
        send_request(OP_ALLOC, 17'd65537, 0, res);
        send_request(OP_ALLOC, 17'h1FFFF, 0, res);
        send_request(OP_ALLOC, HEAP_MAX, 0, res);
        // table is empty now
        send_request(OP_ALLOC, 0, 0, res);
        send_request(OP_FREE, 17'h1FFFF, 16'hFFFF, res);
        send_request(OP_FREE, 17'd65535, 0, res);
        send_request(OP_FREE, 0, 16'd5, res);
    endtask

    task automatic test_empty_heap();
        t_alloc_result res;
        write_heap_size(0);
        send_request(OP_ALLOC, 0, 0, res);
        send_request(OP_ALLOC, 1, 0, res);
        send_request(OP_FREE, 1, 0, res);
        send_request(OP_FREE, 17'h1FFFF, 16'hFFFF, res);
    endtask

    task automatic test_heap_extremes();
        t_alloc_result res;
        write_heap_size(17'h1FFFF);
        send_request(OP_ALLOC, HEAP_MAX, 0, res);
        send_request(OP_FREE, HEAP_MAX, 0, res);
        write_heap_size(1);
        send_request(OP_ALLOC, 1, 0, res);
        send_request(OP_ALLOC, 1, 0, res);
    endtask

    task automatic test_coalescing();
        t_alloc_result res;
        write_heap_size(40);
        repeat (3) send_request(OP_ALLOC, 10, 0, res);
        send_request(OP_FREE, 10, 0, res);
        send_request(OP_FREE, 10, 20, res);
        // middle block touches both neighbors
        send_request(OP_FREE, 10, 10, res);
        // overlapping free, used count pinned at zero
        send_request(OP_FREE, 50, 30, res);
        send_request(OP_FREE, 1, 40, res);
        send_request(OP_FREE, 1, 16'hFFFF, res);
        send_request(OP_FREE, HEAP_MAX, 39, res);
    endtask

    task automatic test_mixed_traffic();
        logic [LEN_W-1:0] heap_list [7];
        int live_off[$];
        int live_len[$];
        t_alloc_result res;
        t_op op;
        logic [LEN_W-1:0] req;
        logic [OFFSET_BITS-1:0] off;
        int heap;
        int cap;
        int pick;
        int r;
        heap_list = '{1, 64, 256, LEN_W'($urandom_range(2, 4096)), HEAP_MAX, 17'h1FFFF,
                      LEN_W'($urandom_range(65537, 131070))};
        foreach (heap_list[h]) begin
            write_heap_size(heap_list[h]);
            live_off.delete();
            live_len.delete();
            heap = int'(heap_bytes);
            cap  = heap / 6 + 1;
            repeat (62) begin
                pick = -1;
                r    = $urandom_range(99);
                off  = OFFSET_BITS'($urandom);
                if (r < 45) begin
                    op  = OP_ALLOC;
                    req = LEN_W'($urandom_range(1, cap));
                end else if (r < 85 && live_off.size() != 0) begin
                    op   = OP_FREE;
                    pick = $urandom_range(live_off.size() - 1);
                    off  = OFFSET_BITS'(live_off[pick]);
                    req  = (r < 78) ? LEN_W'(live_len[pick])
                                    : LEN_W'($urandom_range(0, live_len[pick]));
                end else if (r < 92) begin
                    op = OP_ALLOC;
                    case ($urandom_range(3))
                        0: req = 0;
                        1: req = LEN_W'(heap);
                        2: req = LEN_W'(heap + 1);
                        default: req = LEN_W'($urandom_range(0, 131071));
                    endcase
                end else begin
                    op  = OP_FREE;
                    off = ($urandom_range(1) != 0) ? OFFSET_BITS'($urandom_range(0, 65535))
                                                   : OFFSET_BITS'($urandom_range(0, heap));
                    req = ($urandom_range(1) != 0) ? LEN_W'($urandom_range(0, 131071))
                                                   : LEN_W'($urandom_range(0, 8));
                end
                send_request(op, req, off, res);
                if (op == OP_ALLOC && res.status == ST_OK && req != 0) begin
                    live_off = {live_off, int'(res.offset)};
                    live_len = {live_len, int'(req)};
                end else if (pick >= 0 && res.status == ST_OK) begin
                    if (int'(req) == live_len[pick]) begin
                        live_off.delete(pick);
                        live_len.delete(pick);
                    end else begin
                        // keep the tail that is still held
                        live_off[pick] += int'(req);
                        live_len[pick] -= int'(req);
                    end
                end
            end
        end
    endtask

    task automatic test_table_full();
        int blk_off[$];
        int blk_len[$];
        bit held[$];
        int order[$];
        t_alloc_result res;
        int req;
        int pick;
        int idx;
        write_heap_size(LEN_W'($urandom_range(36, 56)));
        // carve the whole heap into tiny blocks
        do begin
            req = $urandom_range(1, 2);
            send_request(OP_ALLOC, LEN_W'(req), OFFSET_BITS'($urandom), res);
            if (res.status == ST_OK) begin
                blk_off = {blk_off, int'(res.offset)};
                blk_len = {blk_len, req};
                held    = {held, 1'b1};
            end
        end while (res.status == ST_OK);
        // first pass punches isolated holes, second returns the rest
        for (int pass_no = 0; pass_no < 2; pass_no++) begin
            order.delete();
            foreach (held[k]) begin
                if (held[k] && (pass_no == 1 || k % 2 == 0)) order = {order, k};
            end
            while (order.size() != 0) begin
                pick = $urandom_range(order.size() - 1);
                idx  = order[pick];
                order.delete(pick);
                send_request(OP_FREE, LEN_W'(blk_len[idx]), OFFSET_BITS'(blk_off[idx]), res);
                if (res.status == ST_OK) held[idx] = 1'b0;
            end
            // stray single bytes mostly need a fresh entry in a full table
            if (pass_no == 0) begin
                repeat (4) send_request(OP_FREE, 1,
                                        OFFSET_BITS'($urandom_range(0, int'(heap_bytes) - 1)),
                                        res);
            end
        end
    endtask

    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("** first_fit_coalescing_allocator: FAILED **");
        $finish;
    end

    initial begin
        heap_reinit(HEAP_MAX);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 24;
        recv_idle_pct = 58;
        test_boundary_requests();
        test_empty_heap();
        test_heap_extremes();
        test_coalescing();
        test_mixed_traffic();
        test_table_full();
        test_table_full();

        send_idle_pct = 58;
        recv_idle_pct = 24;
        test_mixed_traffic();
        test_table_full();
        test_table_full();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_mixed_traffic();
        test_table_full();
        test_table_full();

        wait_drained(TAIL_CYCLES);
        $display("ran %0d requests across %0d heap_size writes, %0d replies checked",
                 requests_sent, heap_writes, replies_checked);
        $display("reply mix: %0d ok, %0d no fit, %0d outside heap, %0d table full",
                 status_seen[ST_OK], status_seen[ST_NO_FIT], status_seen[ST_BAD_OFFSET],
                 status_seen[ST_TABLE_FULL]);
        if (mismatch_count == 0) begin
            $display("** first_fit_coalescing_allocator: PASSED **");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("** first_fit_coalescing_allocator: FAILED **");
        end
        $finish;
    end

endmodule
